// ===== src/dtmc_pkg.sv =====
// Shared types, constants and the motif classification table for the triad census.
package dtmc_pkg;

    localparam int ROW_W      = 64;
    localparam int NODE_CNT_W = 7;
    localparam int TYPE_W     = 4;
    localparam int COUNT_W    = 16;
    localparam int TYPE_COUNT = 13;
    localparam int PAT_COUNT  = 12;

    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 7'd64;
    localparam logic [NODE_CNT_W-1:0] MIN_TRIPLE   = 7'd3;

    // motif type codes that need special handling
    localparam logic [TYPE_W-1:0] MT_NONE      = 4'd0;
    localparam logic [TYPE_W-1:0] MT_SPLIT_IN  = 4'd8;
    localparam logic [TYPE_W-1:0] MT_SPLIT_OUT = 4'd10;

    localparam logic [1:0] DEG_TWO = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             row_last;
    } row_item_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  motif_type;
        logic [COUNT_W-1:0] motif_count;
        logic               count_last;
    } count_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write accepted row
        logic start;     // clear counters, first triple
        logic rd_i;      // fetch row i
        logic rd_j;      // fetch row j
        logic scan;      // fetch row k, issue triple
        logic rpt_step;  // one count item taken
    } dtmc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic n_small;
        logic i_last;
        logic j_last;
        logic k_last;
        logic pipe_empty;
        logic rpt_last;
    } dtmc_stat_t;

    // 3x3 edge matrix of one triple, adj[from][to]
    typedef logic [2:0][2:0] edge_mat_t;

    // out-degree histogram 0..2, in-degree histogram 0..2, motif type
    typedef struct packed {
        logic [1:0]        oh0;
        logic [1:0]        oh1;
        logic [1:0]        oh2;
        logic [1:0]        ih0;
        logic [1:0]        ih1;
        logic [1:0]        ih2;
        logic [TYPE_W-1:0] mtype;
    } motif_pat_t;

    localparam motif_pat_t MOTIF_PATS [PAT_COUNT] = '{
        '{2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 4'd1},
        '{2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 4'd2},
        '{2'd1, 2'd1, 2'd1, 2'd0, 2'd3, 2'd0, 4'd3},
        '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 4'd4},
        '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 4'd5},
        '{2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 4'd6},
        '{2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd1, 4'd7},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, MT_SPLIT_IN},
        '{2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 2'd0, 4'd9},
        '{2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 4'd11},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 4'd12},
        '{2'd0, 2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 4'd13}
    };

    // Degree histograms -> motif type; MT_NONE when no pattern matches.
    function automatic logic [TYPE_W-1:0] motif_classify(input edge_mat_t adj);
        logic [2:0][1:0]   outd;
        logic [2:0][1:0]   ind;
        logic [2:0][1:0]   oh;
        logic [2:0][1:0]   ih;
        logic [TYPE_W-1:0] mt;
        logic              hit;
        outd = '0;
        ind  = '0;
        oh   = '0;
        ih   = '0;
        mt   = MT_NONE;
        hit  = 1'b0;
        for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
                if (n != m) begin
                    outd[m] = outd[m] + 2'(adj[m][n]);
                    ind[m]  = ind[m] + 2'(adj[n][m]);
                end
            end
        end
        for (int d = 0; d < 3; d++) begin
            for (int m = 0; m < 3; m++) begin
                if (outd[m] == 2'(d)) oh[d] = oh[d] + 2'd1;
                if (ind[m] == 2'(d))  ih[d] = ih[d] + 2'd1;
            end
        end
        for (int p = 0; p < PAT_COUNT; p++) begin
            if (!hit && MOTIF_PATS[p].oh0 == oh[0] && MOTIF_PATS[p].oh1 == oh[1] &&
                MOTIF_PATS[p].oh2 == oh[2] && MOTIF_PATS[p].ih0 == ih[0] &&
                MOTIF_PATS[p].ih1 == ih[1] && MOTIF_PATS[p].ih2 == ih[2]) begin
                hit = 1'b1;
                mt  = MOTIF_PATS[p].mtype;
            end
        end
        // shared histogram pair: decided by the in-degree of the out-degree-two node
        if (mt == MT_SPLIT_IN) begin
            mt = MT_SPLIT_OUT;
            for (int m = 0; m < 3; m++) begin
                if (outd[m] == DEG_TWO && ind[m] == DEG_TWO) mt = MT_SPLIT_IN;
            end
        end
        return mt;
    endfunction

endpackage

// ===== src/directed_triad_motif_census.sv =====
// Top level of the directed triad motif census.
// Rows of the adjacency matrix arrive one item per cycle (in_stall low while
// loading) into a two-port store of MAX_NODES rows of 64 bits; rows past
// MAX_NODES are dropped. The item flagged row_last closes the graph and
// starts the census over node_count nodes (clamped to MAX_NODES): every
// triple i<j<k is classified into motif types 1..13 and counted, and then
// the 13 counts go out as items in type order, count_last on type 13. The
// store has one read port, so the walk reads row i each time i advances,
// row j once per (i,j) pair and row k once per triple; then the classify
// pipeline drains and the 13 counts are reported. No input is taken from
// row_last until the last count item is accepted. Diagonal bits and
// columns at or above node_count never enter a count. node_count below
// three gives an all-zero report. Write node_count only while idle; the
// config port is always ready.
module directed_triad_motif_census #(
    parameter int MAX_NODES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dtmc_pkg::row_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dtmc_pkg::count_item_t             out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dtmc_pkg::NODE_CNT_W-1:0]   cfg_data
);
    import dtmc_pkg::*;

    dtmc_cmd_t  cmd;
    dtmc_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    dtmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .row_last  (in_data.row_last),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // store, walk, classify, count
    dtmc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // loading and reporting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall && out_valid))
        else $error("row item accepted during report");

    // census only starts from an accepted last row
    a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> $past(in_valid && !in_stall && in_data.row_last))
        else $error("census start without last row");

    // counts are settled before they are shown
    a_settled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stat.pipe_empty)
        else $error("report while classify pipeline busy");

    // report ends after the flagged item
    a_rpt_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.count_last) |=> !out_valid)
        else $error("report continues past last count");
`endif

endmodule

// ===== src/dtmc_ctrl.sv =====
// Census sequencer: load, triple walk, pipeline drain and count report.
module dtmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 row_last,
    input  logic                 out_stall,
    input  dtmc_pkg::dtmc_stat_t stat,
    output dtmc_pkg::dtmc_cmd_t  cmd,
    output logic                 in_stall,
    output logic                 out_valid
);
    import dtmc_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_START  = 7'b0000010,
        ST_RD_I   = 7'b0000100,
        ST_RD_J   = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_REPORT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
                if (in_valid && row_last) state_next = ST_START;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = stat.n_small ? ST_REPORT : ST_RD_I;
            end
            ST_RD_I:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.k_last)
                begin
                    if (!stat.j_last)     state_next = ST_RD_J;
                    else if (stat.i_last) state_next = ST_DRAIN;
                    else                  state_next = ST_RD_I;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty) state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                out_valid    = 1'b1;
                cmd.rpt_step = !out_stall;
                if (!out_stall && stat.rpt_last) state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== src/dtmc_dp.sv =====
// Census datapath: adjacency memory, triple indices, classify pipeline, counters.
module dtmc_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtmc_pkg::dtmc_cmd_t                 cmd,
    input  dtmc_pkg::row_item_t                 in_data,
    input  logic                                cfg_we,
    input  logic [dtmc_pkg::NODE_CNT_W-1:0]     cfg_data,
    output dtmc_pkg::dtmc_stat_t                stat,
    output dtmc_pkg::count_item_t               out_data
);
    import dtmc_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int N_W   = $clog2(MAX_NODES + 1);

    logic [ROW_W-1:0] mem [MAX_NODES];
    logic [ROW_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [NODE_CNT_W-1:0] node_count_reg;
    logic [N_W-1:0]        n_eff;
    logic [N_W-1:0]        row_ptr_reg;

    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic             rdi_q_reg, rdj_q_reg;
    logic [ROW_W-1:0] row_i_reg, row_j_reg;

    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_i_reg, s1_j_reg, s1_k_reg;
    logic             s2_valid_reg;
    edge_mat_t        s2_adj_reg;
    edge_mat_t        adj;
    logic             s3_valid_reg;
    logic [TYPE_W-1:0] s3_type_reg;

    logic [COUNT_W-1:0] cnt_reg [TYPE_COUNT];
    logic [TYPE_W-1:0]  rpt_idx_reg;

    // clamp to what the store holds
    assign n_eff = (node_count_reg > NODE_CNT_W'(MAX_NODES)) ? N_W'(MAX_NODES)
                                                              : node_count_reg[N_W-1:0];

    assign stat.n_small    = node_count_reg < MIN_TRIPLE;
    assign stat.i_last     = (N_W'(i_reg) + N_W'(3)) == n_eff;
    assign stat.j_last     = (N_W'(j_reg) + N_W'(2)) == n_eff;
    assign stat.k_last     = (N_W'(k_reg) + N_W'(1)) == n_eff;
    assign stat.pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign stat.rpt_last   = rpt_idx_reg == TYPE_W'(TYPE_COUNT - 1);

    assign rd_addr = cmd.rd_i ? i_reg : (cmd.rd_j ? j_reg : k_reg);

    // adjacency store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load && row_ptr_reg < N_W'(MAX_NODES))
        begin
            mem[row_ptr_reg[IDX_W-1:0]] <= in_data.row_bits;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_CNT_RST;
            row_ptr_reg    <= '0;
        end
        else
        begin
            if (cfg_we) node_count_reg <= cfg_data;
            if (cmd.start)
            begin
                row_ptr_reg <= '0;
            end
            else if (cmd.load && row_ptr_reg < N_W'(MAX_NODES))
            begin
                row_ptr_reg <= row_ptr_reg + N_W'(1);
            end
        end
    end

    // triple walk i < j < k
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg <= '0;
            j_reg <= IDX_W'(1);
            k_reg <= IDX_W'(2);
        end
        else if (cmd.scan)
        begin
            if (stat.k_last)
            begin
                if (stat.j_last)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                    j_reg <= i_reg + IDX_W'(2);
                    k_reg <= i_reg + IDX_W'(3);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                    k_reg <= j_reg + IDX_W'(2);
                end
            end
            else
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    // row i / row j pass the read register, then land in row_i_reg / row_j_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdi_q_reg    <= 1'b0;
            rdj_q_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            rdi_q_reg    <= cmd.rd_i;
            rdj_q_reg    <= cmd.rd_j;
            s1_valid_reg <= cmd.scan;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        adj       = '0;
        adj[0][1] = row_i_reg[s1_j_reg];
        adj[0][2] = row_i_reg[s1_k_reg];
        adj[1][0] = row_j_reg[s1_i_reg];
        adj[1][2] = row_j_reg[s1_k_reg];
        adj[2][0] = rd_data_reg[s1_i_reg];
        adj[2][1] = rd_data_reg[s1_j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rdi_q_reg) row_i_reg <= rd_data_reg;
        if (rdj_q_reg) row_j_reg <= rd_data_reg;
        s1_i_reg    <= i_reg;
        s1_j_reg    <= j_reg;
        s1_k_reg    <= k_reg;
        s2_adj_reg  <= adj;
        s3_type_reg <= motif_classify(s2_adj_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TYPE_COUNT; t++) cnt_reg[t] <= '0;
            rpt_idx_reg <= '0;
        end
        else
        begin
            for (int t = 0; t < TYPE_COUNT; t++)
            begin
                if (cmd.start)
                begin
                    cnt_reg[t] <= '0;
                end
                else if (s3_valid_reg && s3_type_reg == TYPE_W'(t + 1))
                begin
                    cnt_reg[t] <= cnt_reg[t] + COUNT_W'(1);
                end
            end
            if (cmd.start || (cmd.rpt_step && stat.rpt_last))
            begin
                rpt_idx_reg <= '0;
            end
            else if (cmd.rpt_step)
            begin
                rpt_idx_reg <= rpt_idx_reg + TYPE_W'(1);
            end
        end
    end

    assign out_data.motif_type  = rpt_idx_reg + TYPE_W'(1);
    assign out_data.motif_count = cnt_reg[rpt_idx_reg];
    assign out_data.count_last  = stat.rpt_last;

endmodule

// ===== dv/tb_directed_triad_motif_census.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the directed triad census: graph loads, count reports, node_count sweep.
module tb_directed_triad_motif_census;
    import dtmc_pkg::*;

    localparam int ROWS_MAX    = 64;       // store depth of the block as instantiated
    localparam int RAND_ROWS   = 460;      // rows of random graphs to load
    localparam int SETTLE_CYC  = 20;       // quiet cycles before a node_count write and at the end
    localparam int CYCLE_LIMIT = 4000000;  // watchdog, several times the slowest correct run
    localparam int IDLE_PCT    = 14;       // percent of cycles either side holds back

    localparam logic [ROW_W-1:0] ALL_ONES = '1;

    // Keeps a private copy of the adjacency rows and node_count, runs the census
    // itself when a last row goes in, and holds the 13 counts it predicts.
    class census_scoreboard;
        logic [ROW_W-1:0] adjacency [ROWS_MAX];
        int unsigned      next_row;
        int unsigned      nodes;
        count_item_t      pending_counts [$];
        int unsigned      errors;
        int unsigned      checked;

        function new();
            next_row = 0;
            nodes    = NODE_CNT_RST;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_nodes(logic [NODE_CNT_W-1:0] value);
            nodes = value;
        endfunction

        function void note_row(row_item_t item);
            logic [COUNT_W-1:0] tally [TYPE_COUNT];
            int                 span;
            int unsigned        nd [3];
            int unsigned        outd [3];
            int unsigned        ind [3];
            int unsigned        oh [3];
            int unsigned        ih [3];
            logic [TYPE_W-1:0]  mt;
            count_item_t        report;
            // rows past the store depth are dropped, the pointer sticks
            if (next_row < ROWS_MAX) begin
                adjacency[next_row] = item.row_bits;
                next_row++;
            end
            if (!item.row_last)
                return;
            span = (nodes > ROWS_MAX) ? ROWS_MAX : nodes;
            foreach (tally[t])
                tally[t] = '0;
            // only edges between distinct nodes below span are ever looked at,
            // which drops diagonal bits and high columns
            for (int a = 0; a + 2 < span; a++)
                for (int b = a + 1; b + 1 < span; b++)
                    for (int c = b + 1; c < span; c++) begin
                        nd = '{a, b, c};
                        oh = '{0, 0, 0};
                        ih = '{0, 0, 0};
                        for (int m = 0; m < 3; m++) begin
                            outd[m] = 0;
                            ind[m]  = 0;
                            for (int q = 0; q < 3; q++)
                                if (q != m) begin
                                    outd[m] += adjacency[nd[m]][nd[q]];
                                    ind[m]  += adjacency[nd[q]][nd[m]];
                                end
                        end
                        for (int m = 0; m < 3; m++) begin
                            oh[outd[m]]++;
                            ih[ind[m]]++;
                        end
                        // key: out-degree histogram 0..2, then in-degree histogram 0..2
                        case ({2'(oh[0]), 2'(oh[1]), 2'(oh[2]), 2'(ih[0]), 2'(ih[1]), 2'(ih[2])})
                            {2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0}: mt = 4'd1;
                            {2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0}: mt = 4'd2;
                            {2'd1, 2'd1, 2'd1, 2'd0, 2'd3, 2'd0}: mt = 4'd3;
                            {2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1}: mt = 4'd4;
                            {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}: mt = 4'd5;
                            {2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1}: mt = 4'd6;
                            {2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd1}: mt = 4'd7;
                            {2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1}: begin
                                // shared histograms: the out-degree-two node decides
                                mt = MT_SPLIT_OUT;
                                for (int m = 0; m < 3; m++)
                                    if (outd[m] == 2)
                                        mt = (ind[m] == 2) ? MT_SPLIT_IN : MT_SPLIT_OUT;
                            end
                            {2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 2'd0}: mt = 4'd9;
                            {2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2}: mt = 4'd11;
                            {2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2}: mt = 4'd12;
                            {2'd0, 2'd0, 2'd3, 2'd0, 2'd0, 2'd3}: mt = 4'd13;
                            default:                              mt = MT_NONE;
                        endcase
                        if (mt != MT_NONE)
                            tally[mt - 1] = tally[mt - 1] + 1'b1;
                    end
            for (int t = 0; t < TYPE_COUNT; t++) begin
                report.motif_type  = TYPE_W'(t + 1);
                report.motif_count = tally[t];
                report.count_last  = (t == TYPE_COUNT - 1);
                pending_counts.push_back(report);
            end
            next_row = 0;
        endfunction

        function void check_count(count_item_t got);
            count_item_t want;
            checked++;
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected count item, expected none, got type %0d count %0d last %0b",
                         $time, got.motif_type, got.motif_count, got.count_last);
                errors++;
                return;
            end
            want = pending_counts.pop_front();
            if (got.motif_type !== want.motif_type) begin
                $display("%0t: motif_type mismatch, expected %0d, got %0d",
                         $time, want.motif_type, got.motif_type);
                errors++;
            end
            if (got.motif_count !== want.motif_count) begin
                $display("%0t: motif_count mismatch on type %0d, expected %0d, got %0d",
                         $time, want.motif_type, want.motif_count, got.motif_count);
                errors++;
            end
            if (got.count_last !== want.count_last) begin
                $display("%0t: count_last mismatch on type %0d, expected %0b, got %0b",
                         $time, want.motif_type, want.count_last, got.count_last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    row_item_t             in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    count_item_t           out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [NODE_CNT_W-1:0] cfg_data  = '0;

    logic                  calm      = 1'b0;  // high: neither side idles
    int unsigned           cycle_count = 0;
    int unsigned           cur_nodes   = NODE_CNT_RST;
    int unsigned           rows_loaded = 0;   // highest row written since reset
    int unsigned           rows_sent   = 0;
    int unsigned           graphs_sent = 0;
    int unsigned           cfg_writes  = 0;
    int unsigned           widest      = 0;
    int unsigned           max_cfg     = 0;   // largest node_count written

    census_scoreboard sb = new();

    directed_triad_motif_census DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a census that never reports ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d counts outstanding",
                     $time, sb.pending_counts.size());
            $display("FAIL");
            $finish;
        end
    end

    // Both handshakes are sampled on the edge; the values seen are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_row(in_data);
            if (out_valid && !out_stall)
                sb.check_count(out_data);
        end
    end

    // Receiver back-pressure, random outside the calm stretch.
    always @(posedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // One row item; an optional idle gap first, then held until taken.
    task automatic send_row(input row_item_t item);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // A whole graph, last flag on the final row. The next graph may follow at
    // once, so rows also queue up against the census stall.
    task automatic send_graph(input logic [ROW_W-1:0] words [$]);
        row_item_t item;
        int unsigned span;
        foreach (words[w])
        begin
            item.row_bits = words[w];
            item.row_last = (w == words.size() - 1);
            send_row(item);
        end
        in_valid <= 1'b0;
        span = (cur_nodes > ROWS_MAX) ? ROWS_MAX : cur_nodes;
        if (words.size() > rows_loaded)
            rows_loaded = (words.size() > ROWS_MAX) ? ROWS_MAX : words.size();
        if (span >= 3 && span > widest)
            widest = span;
        rows_sent += words.size();
        graphs_sent++;
    endtask

    // Drain every outstanding count, then give the block time to finish any load.
    // The first edge lets the monitor note a last row taken on the edge just passed.
    task automatic settle();
        @(posedge clk);
        while (sb.pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // node_count is only ever changed with the block idle.
    task automatic write_nodes(input logic [NODE_CNT_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_nodes(value);
        cur_nodes = value;
        if (value > max_cfg)
            max_cfg = value;
        cfg_writes++;
    endtask

    // mode 0 sparse, 1 even, 2 dense rows
    function automatic logic [ROW_W-1:0] random_word(input int unsigned mode);
        case (mode)
            0:       return {$urandom, $urandom} & {$urandom, $urandom};
            1:       return {$urandom, $urandom};
            default: return {$urandom, $urandom} | {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [ROW_W-1:0]      words [$];
        logic [NODE_CNT_W-1:0] value;
        int unsigned           span;
        int unsigned           n_rows;
        int unsigned           pick;
        int unsigned           directed_rows;
        bit                    big;
        bit                    was_big;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on zero, two, three and four nodes.
        write_nodes(MIN_TRIPLE);
        // complete triple; diagonal and high columns set too
        words = {ALL_ONES, ALL_ONES, ALL_ONES};
        send_graph(words);
        // empty graph
        words = {64'd0, 64'd0, 64'd0};
        send_graph(words);
        // out-degree-two node with in-degree two
        words = {64'h6, 64'h1, 64'h1};
        send_graph(words);
        // same histograms, out-degree-two node with in-degree one
        words = {64'h6, 64'h4, 64'h1};
        send_graph(words);
        // fewer than three nodes: nothing read, all counts zero
        write_nodes(NODE_CNT_W'(0));
        words = {ALL_ONES};
        send_graph(words);
        write_nodes(NODE_CNT_W'(2));
        words = {random_word(1)};
        send_graph(words);
        write_nodes(NODE_CNT_W'(4));
        words = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0};
        send_graph(words);
        // one row only: the other rows come from the previous graph
        write_nodes(MIN_TRIPLE);
        words = {64'h2};
        send_graph(words);
        directed_rows = rows_sent;

        // Random graphs: mostly small, a few at full depth with overflow rows.
        was_big = 1'b0;
        for (int g = 0; rows_sent - directed_rows < RAND_ROWS; g++)
        begin
            calm <= (g >= 12 && g < 22);
            big = (g % 20 == 5);
            if (big || was_big || $urandom_range(1) == 0)
            begin
                pick = $urandom_range(99);
                if (big)
                    value = $urandom_range(1) ? NODE_CNT_RST
                                              : NODE_CNT_W'($urandom_range(65, 127));
                else if (pick < 5)
                    value = NODE_CNT_W'($urandom_range(0, 2));
                else if (pick < 78)
                    value = NODE_CNT_W'($urandom_range(3, 10));
                else
                    value = NODE_CNT_W'($urandom_range(11, 24));
                write_nodes(value);
            end
            was_big = big;
            span = (cur_nodes > ROWS_MAX) ? ROWS_MAX : cur_nodes;
            if (big)
                n_rows = ROWS_MAX + $urandom_range(0, 4);
            else if (span < 3)
                n_rows = $urandom_range(1, 4);
            else if (span <= rows_loaded && $urandom_range(3) == 0)
                n_rows = $urandom_range(1, span);
            else
                n_rows = span + $urandom_range(0, 2);
            pick  = $urandom_range(2);
            words = {};
            repeat (n_rows) words.push_back(random_word(pick));
            send_graph(words);
        end

        calm <= 1'b0;
        settle();

        $display("Summary: %0d graphs, %0d rows loaded, %0d count items checked, %0d node_count writes",
                 graphs_sent, rows_sent, sb.checked, cfg_writes);
        $display("Census sizes up to %0d nodes; node_count written from zero up to %0d",
                 widest, max_cfg);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
